### hdl/vnl_pkg.sv
`timescale 1ns / 1ps
package vnl_pkg;

    localparam int unsigned SqrtSteps = 16;
    localparam int unsigned DivSteps  = 15;
    localparam int unsigned NumW      = 30;

    // item passed from front to back through the queue
    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic        sx;
        logic        sy;
        logic        sz;
        logic [31:0] sumsq;
    } t_item;

    // square root pipeline stage contents
    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic        sx;
        logic        sy;
        logic        sz;
        logic [31:0] rem;
        logic [31:0] res;
    } t_sq;

    // division pipeline stage contents
    typedef struct packed {
        logic            sx;
        logic            sy;
        logic            sz;
        logic            deg;
        logic [15:0]     len;
        logic [NumW-1:0] rx;
        logic [NumW-1:0] ry;
        logic [NumW-1:0] rz;
        logic [14:0]     qx;
        logic [14:0]     qy;
        logic [14:0]     qz;
    } t_dv;

    // one step of the digit-by-digit square root
    function automatic t_sq sqrt_step(input t_sq s, input int unsigned k);
        logic [31:0] bitv;
        logic [32:0] sum;
        t_sq         o;
        bitv = 32'h4000_0000 >> (2 * k);
        sum  = {1'b0, s.res} + {1'b0, bitv};
        o    = s;
        if ({1'b0, s.rem} >= sum) begin
            o.rem = s.rem - sum[31:0];
            o.res = (s.res >> 1) + bitv;
        end else begin
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // one restoring division step on the remainder
    function automatic logic [NumW:0] div_step(input logic [NumW-1:0] rem,
                                               input logic [15:0] len,
                                               input int unsigned k);
        logic [NumW-1:0] d;
        d = {{(NumW-16){1'b0}}, len} << k;
        if (rem >= d) begin
            return {1'b1, rem - d};
        end
        return {1'b0, rem};
    endfunction

endpackage

### hdl/vnl_front.sv
`timescale 1ns / 1ps
module vnl_front import vnl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [15:0] i_vec_x,
    input  logic [15:0] i_vec_y,
    input  logic [15:0] i_vec_z,
    output logic        o_push,
    output t_item       o_item
);

    logic        r_valid;
    logic [15:0] r_ax, r_ay, r_az;
    logic        r_sx, r_sy, r_sz;
    logic [31:0] w_px, w_py, w_pz;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    // split sign and magnitude
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sx <= i_vec_x[15];
            r_sy <= i_vec_y[15];
            r_sz <= i_vec_z[15];
            r_ax <= i_vec_x[15] ? (16'd0 - i_vec_x) : i_vec_x;
            r_ay <= i_vec_y[15] ? (16'd0 - i_vec_y) : i_vec_y;
            r_az <= i_vec_z[15] ? (16'd0 - i_vec_z) : i_vec_z;
        end
    end

    // sum of squares
    assign w_px = r_ax * r_ax;
    assign w_py = r_ay * r_ay;
    assign w_pz = r_az * r_az;

    assign o_push       = r_valid;
    assign o_item.ax    = r_ax;
    assign o_item.ay    = r_ay;
    assign o_item.az    = r_az;
    assign o_item.sx    = r_sx;
    assign o_item.sy    = r_sy;
    assign o_item.sz    = r_sz;
    assign o_item.sumsq = w_px + w_py + w_pz;

endmodule

### hdl/vnl_fifo.sv
`timescale 1ns / 1ps
module vnl_fifo import vnl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_empty,
    output logic  o_full,
    output t_item o_item
);

    t_item       r_mem [0:1];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push, w_pop;

    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_item  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count did not advance on push");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !w_pop)
        else $error("pop from empty queue");

endmodule

### hdl/vnl_back.sv
`timescale 1ns / 1ps
module vnl_back import vnl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic [15:0] i_min_length,
    output logic        o_valid,
    output logic [15:0] o_dir_x,
    output logic [15:0] o_dir_y,
    output logic [15:0] o_dir_z,
    output logic [15:0] o_magnitude,
    output logic        o_ok
);

    t_sq          w_sq [0:SqrtSteps];
    t_sq          r_sq [1:SqrtSteps];
    logic         r_sv [1:SqrtSteps];
    t_dv          r_dv [0:DivSteps];
    logic         r_dvv [0:DivSteps];
    t_sq          w_last;
    logic [15:0]  w_len;
    logic         w_up;
    t_dv          w_fin;

    // square root stage input
    assign w_sq[0].ax  = i_item.ax;
    assign w_sq[0].ay  = i_item.ay;
    assign w_sq[0].az  = i_item.az;
    assign w_sq[0].sx  = i_item.sx;
    assign w_sq[0].sy  = i_item.sy;
    assign w_sq[0].sz  = i_item.sz;
    assign w_sq[0].rem = i_item.sumsq;
    assign w_sq[0].res = 32'd0;

    // square root pipeline, one result bit per stage
    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            r_sq[k+1] <= sqrt_step(w_sq[k], k);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (k == 0) begin
                r_sv[k+1] <= i_valid;
            end else begin
                r_sv[k+1] <= r_sv[k];
            end
        end
        assign w_sq[k+1] = r_sq[k+1];
    end

    // round to nearest and check against the minimum
    assign w_last = w_sq[SqrtSteps];
    assign w_up   = (w_last.rem > w_last.res);
    assign w_len  = w_last.res[15:0] + {15'd0, w_up};

    always_ff @(posedge i_clk) begin
        r_dv[0].sx  <= w_last.sx;
        r_dv[0].sy  <= w_last.sy;
        r_dv[0].sz  <= w_last.sz;
        r_dv[0].len <= w_len;
        r_dv[0].deg <= (w_len <= i_min_length);
        r_dv[0].rx  <= {w_last.ax, 14'd0} + {15'd0, w_len[15:1]};
        r_dv[0].ry  <= {w_last.ay, 14'd0} + {15'd0, w_len[15:1]};
        r_dv[0].rz  <= {w_last.az, 14'd0} + {15'd0, w_len[15:1]};
        r_dv[0].qx  <= 15'd0;
        r_dv[0].qy  <= 15'd0;
        r_dv[0].qz  <= 15'd0;
    end

    // division pipeline, one quotient bit per stage for each lane
    for (genvar j = 0; j < DivSteps; j++) begin : g_dv
        logic [NumW:0] w_x, w_y, w_z;
        assign w_x = div_step(r_dv[j].rx, r_dv[j].len, DivSteps - 1 - j);
        assign w_y = div_step(r_dv[j].ry, r_dv[j].len, DivSteps - 1 - j);
        assign w_z = div_step(r_dv[j].rz, r_dv[j].len, DivSteps - 1 - j);
        always_ff @(posedge i_clk) begin
            r_dv[j+1].sx  <= r_dv[j].sx;
            r_dv[j+1].sy  <= r_dv[j].sy;
            r_dv[j+1].sz  <= r_dv[j].sz;
            r_dv[j+1].deg <= r_dv[j].deg;
            r_dv[j+1].len <= r_dv[j].len;
            r_dv[j+1].rx  <= w_x[NumW-1:0];
            r_dv[j+1].ry  <= w_y[NumW-1:0];
            r_dv[j+1].rz  <= w_z[NumW-1:0];
            r_dv[j+1].qx  <= {r_dv[j].qx[13:0], w_x[NumW]};
            r_dv[j+1].qy  <= {r_dv[j].qy[13:0], w_y[NumW]};
            r_dv[j+1].qz  <= {r_dv[j].qz[13:0], w_z[NumW]};
        end
    end

    // valid flags through rounding and division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DivSteps; i++) r_dvv[i] <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_dvv[0] <= r_sv[SqrtSteps];
            for (int i = 0; i < DivSteps; i++) r_dvv[i+1] <= r_dvv[i];
            o_valid <= r_dvv[DivSteps];
        end
    end

    // apply signs and zero degenerate vectors
    assign w_fin = r_dv[DivSteps];

    always_ff @(posedge i_clk) begin
        if (w_fin.deg) begin
            o_dir_x     <= 16'd0;
            o_dir_y     <= 16'd0;
            o_dir_z     <= 16'd0;
            o_magnitude <= 16'd0;
            o_ok        <= 1'b0;
        end else begin
            o_dir_x     <= w_fin.sx ? (16'd0 - {1'b0, w_fin.qx}) : {1'b0, w_fin.qx};
            o_dir_y     <= w_fin.sy ? (16'd0 - {1'b0, w_fin.qy}) : {1'b0, w_fin.qy};
            o_dir_z     <= w_fin.sz ? (16'd0 - {1'b0, w_fin.qz}) : {1'b0, w_fin.qz};
            o_magnitude <= w_fin.len;
            o_ok        <= 1'b1;
        end
    end

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok) |-> (o_magnitude != 16'd0))
        else $error("ok result with zero length");
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_magnitude == 16'd0 && o_dir_x == 16'd0
                                && o_dir_y == 16'd0 && o_dir_z == 16'd0))
        else $error("degenerate result not zeroed");
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_dir_x) <= 16'sd16384 && $signed(o_dir_x) >= -16'sd16384))
        else $error("direction out of unit range");

endmodule

### hdl/vector_normalize_with_length.sv
`timescale 1ns / 1ps
// throughput: one item per cycle, set by the fully pipelined square root and divider
// square root takes 16 stages, division 15 stages, front, queue, rounding and output the rest
// reset: synchronous active low, clears all valid flags, the queue and min_length
// the receiver cannot stall, so the queue never fills and busy stays low
module vector_normalize_with_length import vnl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_vec_x,
    input  logic [15:0] i_vec_y,
    input  logic [15:0] i_vec_z,
    output logic        o_valid,
    output logic [15:0] o_dir_x,
    output logic [15:0] o_dir_y,
    output logic [15:0] o_dir_z,
    output logic [15:0] o_magnitude,
    output logic        o_ok,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic        r_min_length_q;
    logic [15:0] r_min_length;
    logic        w_push, w_empty, w_full;
    t_item       w_fitem, w_qitem;

    assign o_cfg_ready = 1'b1;
    assign busy        = w_full;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length   <= 16'd0;
            r_min_length_q <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_length   <= i_cfg_data;
            r_min_length_q <= 1'b1;
        end
    end

    vnl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (start && !busy),
        .i_vec_x  (i_vec_x),
        .i_vec_y  (i_vec_y),
        .i_vec_z  (i_vec_z),
        .o_push   (w_push),
        .o_item   (w_fitem)
    );

    vnl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (!w_empty),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_item  (w_qitem)
    );

    vnl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (!w_empty),
        .i_item       (w_qitem),
        .i_min_length (r_min_length_q ? r_min_length : 16'd0),
        .o_valid      (o_valid),
        .o_dir_x      (o_dir_x),
        .o_dir_y      (o_dir_y),
        .o_dir_z      (o_dir_z),
        .o_magnitude  (o_magnitude),
        .o_ok         (o_ok)
    );

endmodule

### tb/sv/vector_normalize_with_length_test.sv
`timescale 1ns / 1ps
module vector_normalize_with_length_test;

    localparam int Latency    = 35;
    localparam int StallLimit = 2000;

    // one expected normalize result
    typedef struct packed {
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
        logic [15:0] mag;
        logic        ok;
    } t_norm;

    // directed vector with optional hand-typed result
    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        bit          known;
        t_norm       res;
    } t_vec_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_vec_x;
    logic [15:0] i_vec_y;
    logic [15:0] i_vec_z;
    logic        o_valid;
    logic [15:0] o_dir_x;
    logic [15:0] o_dir_y;
    logic [15:0] o_dir_z;
    logic [15:0] o_magnitude;
    logic        o_ok;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    t_norm       pending_norms[$];
    logic [15:0] min_len_model;
    int          fail_count;
    int          vec_count;
    int          res_count;
    int          idle_cycles;
    int          send_idle_pct;
    t_vec_row    cur_row;

    vector_normalize_with_length dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .o_valid     (o_valid),
        .o_dir_x     (o_dir_x),
        .o_dir_y     (o_dir_y),
        .o_dir_z     (o_dir_z),
        .o_magnitude (o_magnitude),
        .o_ok        (o_ok),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // integer square root rounded to nearest, halves up
    function automatic logic [31:0] round_sqrt(input longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (s > r) r += 1;
        return r[31:0];
    endfunction

    // one direction component in Q1.14, rounded half away from zero
    function automatic logic [15:0] unit_comp(input logic signed [15:0] c,
                                              input logic [31:0] len);
        longint unsigned a;
        longint unsigned q;
        a = (c < 0) ? longint'(-int'(c)) : longint'(c);
        q = (a * 16384 + len / 2) / len;
        return (c < 0) ? 16'(-q) : 16'(q);
    endfunction

    // expected result for one vector under the current minimum length
    function automatic t_norm normalize(input logic [15:0] x, input logic [15:0] y,
                                        input logic [15:0] z);
        t_norm           n;
        longint signed   sx;
        longint signed   sy;
        longint signed   sz;
        logic [31:0]     len;
        sx  = longint'(signed'(x));
        sy  = longint'(signed'(y));
        sz  = longint'(signed'(z));
        len = round_sqrt(sx * sx + sy * sy + sz * sz);
        n   = '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0};
        if (len > {16'd0, min_len_model}) begin
            n.dx  = unit_comp(x, len);
            n.dy  = unit_comp(y, len);
            n.dz  = unit_comp(z, len);
            n.mag = len[15:0];
            n.ok  = 1'b1;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_norm e;
        if (i_rst_n && o_valid) begin
            res_count++;
            if (pending_norms.size() == 0) begin
                report_mismatch("unexpected result", o_magnitude, 16'd0);
            end else begin
                e = pending_norms.pop_front();
                if (o_dir_x !== e.dx) report_mismatch("dir_x", o_dir_x, e.dx);
                if (o_dir_y !== e.dy) report_mismatch("dir_y", o_dir_y, e.dy);
                if (o_dir_z !== e.dz) report_mismatch("dir_z", o_dir_z, e.dz);
                if (o_magnitude !== e.mag) report_mismatch("magnitude", o_magnitude, e.mag);
                if (o_ok !== e.ok) report_mismatch("ok", {15'd0, o_ok}, {15'd0, e.ok});
            end
        end
        if (!i_rst_n || o_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= StallLimit) begin
            $display("vector_normalize_with_length verification failed");
            $finish;
        end
    end

    // send one vector and wait for it to be taken
    task automatic send_vec(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input bit known, input t_norm r);
        t_norm p;
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        p = normalize(x, y, z);
        if (known && p != r) begin
            $display("table row disagrees with predictor for %h %h %h", x, y, z);
            fail_count++;
        end
        pending_norms.push_back(known ? r : p);
        vec_count++;
    endtask

    // drain all results, then write the minimum length
    task automatic set_min_len(input logic [15:0] v);
        start <= 1'b0;
        while (pending_norms.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        min_len_model = v;
    endtask

    // random component by mode: unbiased, short, mid-range or full-scale
    function automatic logic [15:0] rand_comp(input int mode);
        case (mode)
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(8) - 4);
            2: return 16'($urandom_range(1023) - 512);
            default: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    t_vec_row vec_table[] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
        '{16'h0001, 16'h0000, 16'h0000, 1'b1, '{16'd16384, 16'd0, 16'd0, 16'd1, 1'b1}},
        '{16'h0000, 16'hffff, 16'h0000, 1'b1, '{16'd0, 16'hc000, 16'd0, 16'd1, 1'b1}},
        '{16'h0000, 16'h0000, 16'h0100, 1'b1, '{16'd0, 16'd0, 16'd16384, 16'd256, 1'b1}},
        '{16'h7fff, 16'h0000, 16'h0000, 1'b1, '{16'd16384, 16'd0, 16'd0, 16'h7fff, 1'b1}},
        '{16'h8000, 16'h0000, 16'h0000, 1'b1, '{16'hc000, 16'd0, 16'd0, 16'h8000, 1'b1}},
        '{16'h8000, 16'h8000, 16'h8000, 1'b0, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
        '{16'h7fff, 16'h7fff, 16'h7fff, 1'b0, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
        '{16'h7fff, 16'h8000, 16'h7fff, 1'b0, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
        '{16'h0003, 16'h0004, 16'h0000, 1'b0, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
        '{16'hfffd, 16'h0004, 16'hfff4, 1'b0, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
        '{16'h0001, 16'h0001, 16'h0000, 1'b0, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
        '{16'h5555, 16'haaaa, 16'h1234, 1'b0, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}}
    };

    initial begin
        logic [15:0] cfg_vals[5];
        int          mode;
        cfg_vals      = '{16'd0, 16'd1, 16'd300, 16'd20000, 16'hffff};
        fail_count    = 0;
        vec_count     = 0;
        res_count     = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        min_len_model = 16'd0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_vec_x       = 16'd0;
        i_vec_y       = 16'd0;
        i_vec_z       = 16'd0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 16'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at reset minimum
        foreach (vec_table[k]) begin
            cur_row = vec_table[k];
            send_vec(cur_row.x, cur_row.y, cur_row.z, cur_row.known, cur_row.res);
        end
        // degenerate threshold edges: length 1 at min 1, length 2 at min 1
        set_min_len(16'd1);
        send_vec(16'h0001, 16'h0000, 16'h0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0});
        send_vec(16'h0002, 16'h0000, 16'h0000, 1'b1, '{16'd16384, 16'd0, 16'd0, 16'd2, 1'b1});
        set_min_len(16'hffff);
        send_vec(16'h8000, 16'h8000, 16'h8000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0});

        // random phases over idling levels and minimum lengths
        for (int ph = 0; ph < 8; ph++) begin
            set_min_len(cfg_vals[ph % 5]);
            send_idle_pct = (ph % 4 == 1) ? 81 : (ph % 4 == 3) ? 20 : 0;
            for (int n = 0; n < 200; n++) begin
                mode = $urandom_range(9);
                mode = (mode < 6) ? 0 : (mode < 8) ? mode - 5 : 3;
                send_vec(rand_comp(mode), rand_comp($urandom_range(2)),
                         rand_comp(mode), 1'b0, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0});
            end
        end

        // drain
        start <= 1'b0;
        while (pending_norms.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);

        $display("sent %0d vectors, checked %0d results", vec_count, res_count);
        $display("covered zero, axis, full-scale vectors and five minimum lengths");
        if (fail_count == 0 && pending_norms.size() == 0)
            $display("vector_normalize_with_length verification clean");
        else
            $display("vector_normalize_with_length verification failed");
        $finish;
    end

endmodule

### vector_normalize_with_length.f
hdl/vnl_pkg.sv
hdl/vnl_front.sv
hdl/vnl_fifo.sv
hdl/vnl_back.sv
hdl/vector_normalize_with_length.sv
tb/sv/vector_normalize_with_length_test.sv
